// File: hdl/mmpf_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message parser package
// Shared types and constants for the MIDI channel-message parser and its
// message queue.
// ----------------------------------------------------------------------------
package mmpf_pkg;

  // Request kind carried by an input beat.
  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  // Upper nibbles of status bytes that matter to the parser.
  localparam logic [3:0] HI_SYSTEM   = 4'hF;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_PRESSURE = 4'hD;

  // Number of data bytes that follow a channel status.
  localparam logic [1:0] DATA_ONE = 2'd1;
  localparam logic [1:0] DATA_TWO = 2'd2;

  // One queued message, 22 bits wide.
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] first;
    logic [6:0] second;
  } msg_t;

  localparam int unsigned MSG_W = $bits(msg_t);

endpackage

// File: hdl/mmpf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module mmpf_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/midi_message_parser_fifo.sv
// ----------------------------------------------------------------------------
// MIDI message parser with message queue
// Assembles raw MIDI bytes into channel messages (with running status) and
// queues them in a ring buffer held in a synchronous RAM. Read requests pop
// one message per beat or report that the queue is empty.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_mode, in_midi_byte
//   out_     output     out_valid/out_stall  out_got_message, out_status_byte,
//                                            out_first_data, out_second_data
//
// Cycles: one input beat is taken every clock while the result side keeps up.
// A MIDI byte is parsed and, when it completes a message, written to the RAM
// in the cycle it is accepted; it produces no result beat. A read request
// reads the RAM in the cycle it is accepted; its result passes through the
// RAM read register and then the output register, which presents the beat.
// Reset: rst_n is synchronous and active low; it empties the queue and clears
// the parser. The RAM itself is not cleared, and no clearing pass is needed.
// Stalls: a read result that cannot move to the output register holds the
// input side, which is stalled until the output register frees up.
// ----------------------------------------------------------------------------
module midi_message_parser_fifo
  import mmpf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_midi_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_got_message,
  output logic [7:0] out_status_byte,
  output logic [6:0] out_first_data,
  output logic [6:0] out_second_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  // Queue pointers.
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;

  // Parser state.
  logic [7:0] cur_status_r, cur_status_nxt;
  logic [6:0] held_first_r, held_first_nxt;
  logic [6:0] held_second_r, held_second_nxt;
  logic [1:0] bytes_exp_r, bytes_exp_nxt;
  logic [1:0] bytes_left_r, bytes_left_nxt;
  logic       status_seen_r, status_seen_nxt;

  // Read pipeline: s1 means the RAM read data belongs to a pending request.
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_got_r, s1_got_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic       out_got_r, out_got_nxt;
  msg_t       out_msg_r, out_msg_nxt;

  logic       in_accept;
  logic       out_advance;
  logic       queue_empty;
  logic       ram_wr_en;
  logic       ram_rd_en;
  msg_t       ram_wr_msg;
  msg_t       ram_rd_msg;
  logic [MSG_W-1:0] ram_rd_data;

  // The output register can take new data when it is empty or being drained.
  assign out_advance = !out_valid_r || !out_stall;
  // Input is held only while a finished read result is stuck in s1.
  assign in_stall    = s1_valid_r && !out_advance;
  assign in_accept   = in_valid && !in_stall;
  assign queue_empty = (rd_ptr_r == wr_ptr_r);

  // Parser and queue control.
  always_comb begin
    logic [3:0] hi;
    logic [1:0] left_dec;

    hi              = in_midi_byte[7:4];
    left_dec        = '0;
    cur_status_nxt  = cur_status_r;
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    bytes_exp_nxt   = bytes_exp_r;
    bytes_left_nxt  = bytes_left_r;
    status_seen_nxt = status_seen_r;
    wr_ptr_nxt      = wr_ptr_r;
    rd_ptr_nxt      = rd_ptr_r;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;

    if (in_accept && mode_t'(in_mode) == MODE_BYTE) begin
      if (in_midi_byte[7]) begin
        // System bytes leave the parse state untouched.
        if (hi != HI_SYSTEM) begin
          cur_status_nxt  = in_midi_byte;
          held_first_nxt  = '0;
          held_second_nxt = '0;
          bytes_exp_nxt   = (hi == HI_PROGRAM || hi == HI_PRESSURE) ? DATA_ONE : DATA_TWO;
          bytes_left_nxt  = bytes_exp_nxt;
          status_seen_nxt = 1'b1;
        end
      end else if (status_seen_r) begin
        if (bytes_left_r == bytes_exp_r) begin
          held_first_nxt = in_midi_byte[6:0];
        end else begin
          held_second_nxt = in_midi_byte[6:0];
        end
        left_dec = (bytes_left_r != 2'd0) ? bytes_left_r - 2'd1 : 2'd0;
        if (left_dec == 2'd0) begin
          // Message complete: reload for running status and queue it.
          bytes_left_nxt = bytes_exp_r;
          ram_wr_en      = 1'b1;
          wr_ptr_nxt     = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
        end else begin
          bytes_left_nxt = left_dec;
        end
      end
    end

    if (in_accept && mode_t'(in_mode) == MODE_READ && !queue_empty) begin
      ram_rd_en  = 1'b1;
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  assign ram_wr_msg = '{status: cur_status_r, first: held_first_nxt, second: held_second_nxt};

  mmpf_ram #(
    .WIDTH (MSG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (ram_wr_msg),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rd_data)
  );

  assign ram_rd_msg = msg_t'(ram_rd_data);

  // Read pipeline and output register.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_got_nxt    = s1_got_r;
    out_valid_nxt = out_valid_r;
    out_got_nxt   = out_got_r;
    out_msg_nxt   = out_msg_r;

    if (out_advance) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_got_nxt = s1_got_r;
        out_msg_nxt = s1_got_r ? ram_rd_msg : '0;
      end
      s1_valid_nxt = 1'b0;
    end

    if (in_accept && mode_t'(in_mode) == MODE_READ) begin
      s1_valid_nxt = 1'b1;
      s1_got_nxt   = !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cur_status_r  <= '0;
      held_first_r  <= '0;
      held_second_r <= '0;
      bytes_exp_r   <= '0;
      bytes_left_r  <= '0;
      status_seen_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      wr_ptr_r      <= wr_ptr_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      cur_status_r  <= cur_status_nxt;
      held_first_r  <= held_first_nxt;
      held_second_r <= held_second_nxt;
      bytes_exp_r   <= bytes_exp_nxt;
      bytes_left_r  <= bytes_left_nxt;
      status_seen_r <= status_seen_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_got_r  <= s1_got_nxt;
    out_got_r <= out_got_nxt;
    out_msg_r <= out_msg_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_got_message = out_got_r;
  assign out_status_byte = out_msg_r.status;
  assign out_first_data  = out_msg_r.first;
  assign out_second_data = out_msg_r.second;

  // A read result waiting in s1 is never dropped while the output is blocked.
  a_s1_held : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_advance |=> s1_valid_r)
    else $error("read result lost in s1");

  // The RAM is only read when the queue holds a message.
  a_rd_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |-> rd_ptr_r != wr_ptr_r)
    else $error("RAM read from empty queue");

  // A beat is either a byte or a read, never both.
  a_rd_wr_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_rd_en && ram_wr_en))
    else $error("RAM read and write in one cycle");

  // An empty answer carries all-zero fields.
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_got_r |-> out_msg_r == '0)
    else $error("empty result with non-zero fields");

  // Before any status the data counters stay idle.
  a_no_status : assert property (@(posedge clk) disable iff (!rst_n)
    !status_seen_r |-> bytes_exp_r == 2'd0 && bytes_left_r == 2'd0)
    else $error("parser counters moved before a status byte");

endmodule

// File: tb/sv/midi_message_parser_fifo_tb.sv
// ----------------------------------------------------------------------------
// MIDI message parser testbench
// Drives MIDI bytes and read requests into the parser, keeps its own model of
// the parser and message queue, and checks every popped message field by field.
// ----------------------------------------------------------------------------
module midi_message_parser_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmpf_pkg::*;

  // The queue runs at its full depth. One flood in the random part runs the
  // write pointer round onto the read pointer, where the queue silently looks
  // empty.
  localparam int DEPTH = 1024;
  localparam int ITEMS = 2000;
  localparam int LIMIT = 200000;
  localparam int DRAIN = 12;

  // What one read request should return.
  typedef struct packed {
    logic got;
    msg_t msg;
  } pop_t;

  // Scoreboard: mirrors the parser and the ring of messages, and holds the
  // read results that are still on their way out of the block.
  class msg_board;
    msg_t       ring [DEPTH];
    int         wr_ix;
    int         rd_ix;
    logic [7:0] cur_status;
    logic [6:0] data_a;
    logic [6:0] data_b;
    logic [1:0] need;
    logic [1:0] remain;
    bit         have_status;
    pop_t       due_pops [$];
    int         errors;

    function void note_beat(mode_t m, logic [7:0] b);
      pop_t p;
      if (m == MODE_READ) begin
        p = '0;
        if (rd_ix != wr_ix) begin
          p.got = 1'b1;
          p.msg = ring[rd_ix];
          rd_ix = (rd_ix + 1) % DEPTH;
        end
        due_pops.push_back(p);
      end else if (b[7]) begin
        // System bytes leave the parser exactly as it was.
        if (b[7:4] != HI_SYSTEM) begin
          cur_status  = b;
          data_a      = '0;
          data_b      = '0;
          need        = (b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESSURE) ? DATA_ONE : DATA_TWO;
          remain      = need;
          have_status = 1'b1;
        end
      end else if (have_status) begin
        if (remain == need) data_a = b[6:0];
        else data_b = b[6:0];
        if (remain > 0) remain--;
        if (remain == 0) begin
          // Running status: the next data bytes start a new message.
          remain = need;
          ring[wr_ix] = {cur_status, data_a, data_b};
          wr_ix = (wr_ix + 1) % DEPTH;
        end
      end
    endfunction

    function void check_result(logic got, logic [7:0] st, logic [6:0] fd, logic [6:0] sd);
      pop_t p;
      if (due_pops.size() == 0) begin
        $display("%0t: unexpected result beat: got_message %b status %h first %h second %h",
                 $time, got, st, fd, sd);
        errors++;
        return;
      end
      p = due_pops.pop_front();
      if (got !== p.got) begin
        $display("%0t: got_message expected %b actual %b", $time, p.got, got);
        errors++;
      end
      if (st !== p.msg.status) begin
        $display("%0t: status_byte expected %h actual %h", $time, p.msg.status, st);
        errors++;
      end
      if (fd !== p.msg.first) begin
        $display("%0t: first_data expected %h actual %h", $time, p.msg.first, fd);
        errors++;
      end
      if (sd !== p.msg.second) begin
        $display("%0t: second_data expected %h actual %h", $time, p.msg.second, sd);
        errors++;
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic       in_mode      = 1'b0;
  logic [7:0] in_midi_byte = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_got_message;
  logic [7:0] out_status_byte;
  logic [6:0] out_first_data;
  logic [6:0] out_second_data;

  msg_board board = new();

  // While calm is set neither side idles, so the block runs flat out.
  bit calm;
  int cycles;
  // Beats sent so far that the block acts on (system bytes are not counted).
  int sent;
  // Data bytes per message under the last channel status sent; zero until
  // the first one.
  int msg_len;

  midi_message_parser_fifo #(
    .QUEUE_DEPTH (DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_midi_byte    (in_midi_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_got_message (out_got_message),
    .out_status_byte (out_status_byte),
    .out_first_data  (out_first_data),
    .out_second_data (out_second_data)
  );

  always #10 clk = ~clk;

  // The watchdog. A healthy run finishes far inside this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL midi_message_parser_fifo");
      $finish;
    end
  end

  // The result side stalls at random, except in the calm stretch.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 31);
    end
  end

  // Both handshakes are sampled here, on the values from before the edge. The
  // input beat is noted first, though a read result can never appear in the
  // cycle its request is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_beat(mode_t'(in_mode), in_midi_byte);
      end
      if (out_valid && !out_stall) begin
        board.check_result(out_got_message, out_status_byte, out_first_data,
                           out_second_data);
      end
    end
  end

  // Presents one beat, after a random number of idle cycles, and returns at
  // the edge where it is taken. Valid is only lowered when a gap follows.
  task automatic send_beat(mode_t m, logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_midi_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(m == MODE_BYTE && b[7:4] == HI_SYSTEM)) sent++;
  endtask

  // Sends a MIDI byte and keeps track of the message length that the
  // generator must follow for well-formed running-status messages.
  task automatic send_byte(logic [7:0] b);
    if (b[7] && b[7:4] != HI_SYSTEM) begin
      msg_len = (b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESSURE) ? 1 : 2;
    end
    send_beat(MODE_BYTE, b);
  endtask

  // Sends whole messages under the current status.
  task automatic send_messages(int count);
    repeat (count) begin
      repeat (msg_len) send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int roll;
    bit flooded;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A read of the empty queue, then data bytes with no
    // status yet, which the parser must throw away.
    send_beat(MODE_READ, 8'hFF);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_beat(MODE_READ, 8'h00);
    // Lowest channel status with the extreme data values, then a second
    // message under running status.
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h3C);
    send_byte(8'h40);
    // Program change and channel pressure take one data byte each.
    send_byte(8'hC5);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'hDF);
    send_byte(8'h55);
    // A partial message cut short by a new status, the highest channel
    // status, and a system byte in the middle of a message.
    send_byte(8'hB0);
    send_byte(8'h10);
    send_byte(8'hEF);
    send_byte(8'h01);
    send_byte(8'hF0);
    send_byte(8'h02);
    // Six messages are queued; the seventh read finds the queue empty.
    repeat (7) send_beat(MODE_READ, 8'hAA);

    // Random part: mostly well-formed messages and reads, with one flood that
    // overruns the queue, broken messages and raw noise mixed in.
    sent = 0;
    while (sent < ITEMS) begin
      calm = (sent >= 1300 && sent < 1650);
      roll = $urandom_range(0, 99);
      if (!flooded && sent >= 150) begin
        // A flood with no reads, long enough to wrap the write pointer.
        // One-data-byte messages keep it short.
        flooded = 1'b1;
        send_byte(8'($urandom_range(8'hC0, 8'hDF)));
        send_messages($urandom_range(DEPTH - 2, DEPTH + 4));
      end else if (roll < 35) begin
        if (msg_len == 0 || $urandom_range(0, 2) == 0) begin
          send_byte(8'($urandom_range(8'h80, 8'hEF)));
        end
        send_messages($urandom_range(1, 3));
      end else if (roll < 75) begin
        repeat ($urandom_range(1, 4)) send_beat(MODE_READ, 8'($urandom_range(0, 255)));
      end else if (roll < 88) begin
        // A status with a missing or interrupted tail.
        send_byte(8'($urandom_range(8'h80, 8'hEF)));
        if ($urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 127)));
        send_byte(8'($urandom_range(8'hF0, 8'hFF)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;

    // Every beat has been taken at this edge, so valid can drop now.
    in_valid <= 1'b0;
    while (board.due_pops.size() != 0) @(posedge clk);
    // Give a stray result beat time to show itself.
    repeat (DRAIN) @(posedge clk);

    if (board.errors == 0) begin
      $display("PASS midi_message_parser_fifo");
    end else begin
      $display("FAIL midi_message_parser_fifo");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mmpf_pkg.sv
hdl/mmpf_ram.sv
hdl/midi_message_parser_fifo.sv
tb/sv/midi_message_parser_fifo_tb.sv
